// ===== rtl/iss_pkg.sv =====
// Shared types, constants and helpers for the irrigation sensor supervisor.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package iss_pkg;

  // Driver status codes
  localparam logic [1:0] STATUS_UNINIT = 2'd1;
  localparam logic [1:0] STATUS_ERR    = 2'd2;
  localparam logic [1:0] STATUS_RSVD   = 2'd3;

  // Configuration register map
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FLOW_MIN       = 3'd0,
    REG_FLOW_MAX       = 3'd1,
    REG_MAX_PERCENT    = 3'd2,
    REG_CONTAINER_SPAN = 3'd3,
    REG_SENSOR_OFFSET  = 3'd4,
    REG_PUMP_ON_DELAY  = 3'd5,
    REG_PUMP_OFF_DELAY = 3'd6,
    REG_REPORT_TICKS   = 3'd7
  } cfg_reg_e;

  // Register reset values
  localparam logic [15:0] RST_FLOW_MIN       = 16'd17;
  localparam logic [15:0] RST_FLOW_MAX       = 16'd500;
  localparam logic [7:0]  RST_MAX_PERCENT    = 8'd85;
  localparam logic [7:0]  RST_CONTAINER_SPAN = 8'd22;
  localparam logic [7:0]  RST_SENSOR_OFFSET  = 8'd1;
  localparam logic [15:0] RST_PUMP_ON_DELAY  = 16'd4;
  localparam logic [15:0] RST_PUMP_OFF_DELAY = 16'd1;
  localparam logic [7:0]  RST_REPORT_TICKS   = 8'd10;

  // Flow accumulator width default
  localparam int unsigned FLOW_WIDTH_DEF = 16;

  // Level percent divider: (255 * 100) fits in 15 bits
  localparam int unsigned LEVEL_SCALE = 100;
  localparam int unsigned DIVIDEND_W  = 15;
  localparam int unsigned DIVISOR_W   = 8;

  typedef struct packed {
    logic        pump_command;
    logic [15:0] flow_sample;
    logic [1:0]  flow_read_status;
    logic [7:0]  level_length;
    logic [1:0]  level_read_status;
    logic [7:0]  moisture_value;
    logic [1:0]  moisture_read_status;
  } iss_in_t;

  typedef struct packed {
    logic [15:0] flow_total;
    logic        flow_total_valid;
    logic [1:0]  flow_status;
    logic [7:0]  level_percent;
    logic        level_valid;
    logic [1:0]  level_status;
    logic [7:0]  moisture_out;
    logic        moisture_valid;
    logic [1:0]  moisture_status;
    logic        pump_qualified;
  } iss_out_t;

  // Status code three is reported as error
  function automatic logic [1:0] norm_status(input logic [1:0] s);
    return (s == STATUS_RSVD) ? STATUS_ERR : s;
  endfunction

endpackage

// ===== rtl/iss_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on iss_pkg for default widths.
`timescale 1ns / 1ps

module iss_div #(
  parameter int unsigned DW = iss_pkg::DIVIDEND_W,
  parameter int unsigned VW = iss_pkg::DIVISOR_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [DW-1:0] quot_o
);
  localparam int unsigned CW = $clog2(DW);
  localparam logic [CW-1:0] LAST_STEP = CW'(DW - 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [VW-1:0] rem_q;
  logic [DW-1:0] quo_q;
  logic [VW-1:0] div_q;

  logic [VW:0]   trial;
  logic          fits;
  logic [VW:0]   diff;

  // Shift next dividend bit into the partial remainder and try a subtract.
  // A zero divisor always fits, so the quotient comes out all ones.
  always_comb begin
    trial = {rem_q, quo_q[DW-1]};
    fits  = (trial >= {1'b0, div_q});
    diff  = trial - {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      div_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        quo_q  <= dividend_i;
        div_q  <= divisor_i;
      end else if (busy_q) begin
        rem_q <= fits ? diff[VW-1:0] : trial[VW-1:0];
        quo_q <= {quo_q[DW-2:0], fits};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== rtl/irrigation_sensor_supervisor_unit.sv =====
// Irrigation sensor supervisor: pump qualification, flow totals, level percent.
// A reporting tick passes S_START and S_WAIT (bit-serial level-percent divider) and
//   loads its result in S_OUT, which waits while the last report is not taken.
// Throughput: 1 tick/cycle between reports; a reporting tick holds ready low until
//   S_OUT has loaded its result.
// Reset: async active low; all counters, pump state and config to defaults.
`timescale 1ns / 1ps

module irrigation_sensor_supervisor_unit #(
  parameter int unsigned FLOW_WIDTH = iss_pkg::FLOW_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // tick transaction in
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  iss_pkg::iss_in_t                   in_data_i,
  // report transaction out
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output iss_pkg::iss_out_t                  out_data_o,
  // config write transaction
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [iss_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [iss_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import iss_pkg::*;

  // Divider widths are fixed by the level range and the 8-bit span
  localparam int unsigned DIV_DW = DIVIDEND_W;
  localparam int unsigned DIV_VW = DIVISOR_W;

  // Compare width for the flow window: wide enough for total and limits
  localparam int unsigned CMPW = (FLOW_WIDTH > 16) ? FLOW_WIDTH : 16;

  typedef enum logic [1:0] {
    S_IDLE,   // accept a tick, update counters
    S_START,  // window check, kick off the divider
    S_WAIT,   // divider running
    S_OUT     // finish level status, load output register
  } state_e;

  // ---------------------------------------------------------------------
  // Configuration registers; writes are always taken
  // ---------------------------------------------------------------------
  logic [15:0] flow_min_q, flow_max_q, on_delay_q, off_delay_q;
  logic [7:0]  max_pct_q, span_q, offset_q, rpt_ticks_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_min_q  <= RST_FLOW_MIN;
      flow_max_q  <= RST_FLOW_MAX;
      max_pct_q   <= RST_MAX_PERCENT;
      span_q      <= RST_CONTAINER_SPAN;
      offset_q    <= RST_SENSOR_OFFSET;
      on_delay_q  <= RST_PUMP_ON_DELAY;
      off_delay_q <= RST_PUMP_OFF_DELAY;
      rpt_ticks_q <= RST_REPORT_TICKS;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_FLOW_MIN:       flow_min_q  <= cfg_data_i;
        REG_FLOW_MAX:       flow_max_q  <= cfg_data_i;
        REG_MAX_PERCENT:    max_pct_q   <= cfg_data_i[7:0];
        REG_CONTAINER_SPAN: span_q      <= cfg_data_i[7:0];
        REG_SENSOR_OFFSET:  offset_q    <= cfg_data_i[7:0];
        REG_PUMP_ON_DELAY:  on_delay_q  <= cfg_data_i;
        REG_PUMP_OFF_DELAY: off_delay_q <= cfg_data_i;
        REG_REPORT_TICKS:   rpt_ticks_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Per-tick state and report working registers
  // ---------------------------------------------------------------------
  state_e                state_q;
  logic                  last_cmd_q;
  logic                  run_q;
  logic [15:0]           pump_cnt_q;
  logic [FLOW_WIDTH-1:0] acc_q;
  logic [7:0]            rpt_cnt_q;

  logic [FLOW_WIDTH-1:0] total_q;
  logic [1:0]            fst_q, lst_q, mst_q;
  logic [7:0]            moist_q;
  logic [7:0]            lvl_t_q;
  logic [DIV_DW-1:0]     quot_q;

  logic                  out_valid_q;
  iss_out_t              out_q;

  // Pump qualification: count restarts on a command change, saturates at max
  logic [15:0]           cnt_base, cnt_new;
  logic                  run_new;
  logic [FLOW_WIDTH-1:0] acc_new;
  logic [7:0]            rpt_new;
  logic                  is_report;

  always_comb begin
    cnt_base = (in_data_i.pump_command != last_cmd_q) ? 16'd0 : pump_cnt_q;
    cnt_new  = (cnt_base == 16'hFFFF) ? cnt_base : cnt_base + 16'd1;
    run_new  = run_q;
    if (in_data_i.pump_command) begin
      if (cnt_new > on_delay_q) run_new = 1'b1;
    end else begin
      if (cnt_new > off_delay_q) run_new = 1'b0;
    end
    acc_new   = acc_q + FLOW_WIDTH'(in_data_i.flow_sample);
    rpt_new   = rpt_cnt_q + 8'd1;
    is_report = (rpt_new == rpt_ticks_q);
  end

  // Flow window check on the latched total, applied only while the pump is qualified
  logic [CMPW-1:0] total_ext;
  logic            out_of_window;

  assign total_ext     = CMPW'(total_q);
  assign out_of_window = run_q && ((total_ext < CMPW'(flow_min_q)) ||
                                   (total_ext > CMPW'(flow_max_q)));

  // ---------------------------------------------------------------------
  // Level divider: (level length + offset) * 100 / span
  // ---------------------------------------------------------------------
  logic              div_start, div_busy, div_done;
  logic [DIV_DW-1:0] div_dividend, div_quot;

  assign div_start    = (state_q == S_START);
  assign div_dividend = DIV_DW'(lvl_t_q) * DIV_DW'(LEVEL_SCALE);

  iss_div #(
    .DW (DIV_DW),
    .VW (DIV_VW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (DIV_VW'(span_q)),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Result assembly; a zero span divides to all ones and saturates too
  logic [7:0] pct;
  logic       lvl_ok;
  logic [1:0] lst_fin;
  logic       fvalid, mvalid;
  iss_out_t   res;

  always_comb begin
    pct     = (|quot_q[DIV_DW-1:8]) ? 8'hFF : quot_q[7:0];
    lvl_ok  = (lst_q != STATUS_UNINIT);
    lst_fin = (lvl_ok && (pct > max_pct_q)) ? STATUS_ERR : lst_q;
    fvalid  = (fst_q != STATUS_UNINIT);
    mvalid  = (mst_q != STATUS_UNINIT);

    res                  = '0;
    res.flow_total       = fvalid ? total_ext[15:0] : 16'd0;
    res.flow_total_valid = fvalid;
    res.flow_status      = fst_q;
    res.level_percent    = lvl_ok ? pct : 8'd0;
    res.level_valid      = lvl_ok;
    res.level_status     = lst_fin;
    res.moisture_out     = mvalid ? moist_q : 8'd0;
    res.moisture_valid   = mvalid;
    res.moisture_status  = mst_q;
    res.pump_qualified   = run_q;
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_cmd_q  <= 1'b0;
      run_q       <= 1'b0;
      pump_cnt_q  <= '0;
      acc_q       <= '0;
      rpt_cnt_q   <= '0;
      total_q     <= '0;
      fst_q       <= '0;
      lst_q       <= '0;
      mst_q       <= '0;
      moist_q     <= '0;
      lvl_t_q     <= '0;
      quot_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // S_OUT handles its own drain-and-reload of the output register
      if (out_valid_q && out_ready_i && state_q != S_OUT) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            last_cmd_q <= in_data_i.pump_command;
            pump_cnt_q <= cnt_new;
            run_q      <= run_new;
            if (is_report) begin
              rpt_cnt_q <= '0;
              acc_q     <= '0;
              total_q   <= acc_new;
              fst_q     <= norm_status(in_data_i.flow_read_status);
              lst_q     <= norm_status(in_data_i.level_read_status);
              mst_q     <= norm_status(in_data_i.moisture_read_status);
              moist_q   <= in_data_i.moisture_value;
              lvl_t_q   <= in_data_i.level_length + offset_q;
              state_q   <= S_START;
            end else begin
              rpt_cnt_q <= rpt_new;
              acc_q     <= acc_new;
            end
          end
        end
        S_START: begin
          if (out_of_window) fst_q <= STATUS_ERR;
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            quot_q  <= div_quot;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          // output register free, or being emptied this cycle
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
`ifndef SYNTHESIS
  // no tick accepted while the divider is still working
  a_ready_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_busy)
    else $error("input ready while divider busy");

  // divider completes only while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_WAIT))
    else $error("divider done outside wait state");

  // a report loaded in S_OUT is valid next and leaves the sequencer idle
  a_out_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && (!out_valid_o || out_ready_i)) |=>
      (out_valid_o && state_q == S_IDLE))
    else $error("report not loaded from output state");

  // uninitialized level never carries a percent
  a_level_uninit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.level_status == STATUS_UNINIT) |->
      (out_data_o.level_percent == 8'd0 && !out_data_o.level_valid))
    else $error("uninitialized level with nonzero percent");
`endif

endmodule
